@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the plotter RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication (or any property) on every clock edge outside reset.
`define JRSP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");

// Flag a condition that must never be true outside reset.
`define JRSP_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

@@ rtl/jrsp_pkg.sv @@
// ---------------------------------------------------------------------------
// jrsp_pkg
// Types, constants and helper functions of the random-sample Julia plotter.
// ---------------------------------------------------------------------------
package jrsp_pkg;

   localparam logic [31:0] TAUS_MASK_A = 32'hFFFF_FFFE;
   localparam logic [31:0] TAUS_MASK_B = 32'hFFFF_FFF8;
   localparam logic [31:0] TAUS_MASK_C = 32'hFFFF_FFF0;

   localparam logic [31:0] SEED_A_RESET = 32'h1234_5678;
   localparam logic [31:0] SEED_B_RESET = 32'h9ABC_DEF0;
   localparam logic [31:0] SEED_C_RESET = 32'h0F1E_2D3C;

   // (7 + 0.5287663729) in Q16, plus 16.0 for the second log offset
   localparam int unsigned COLOUR_BIAS = 493405;
   localparam int unsigned COLOUR_OFFS = COLOUR_BIAS + (16 << 16);
   localparam logic [16:0] AMOUNT_MAX  = 17'h1FFFF;

   localparam int unsigned LOG_W = 22;   // 6 integer bits, 16 fraction bits

   typedef enum logic [2:0] {
      CSR_VIEW_RE    = 3'd0,
      CSR_VIEW_IM    = 3'd1,
      CSR_MAX_ITER   = 3'd2,
      CSR_IMAGE_SIZE = 3'd3,
      CSR_ESCAPE     = 3'd4,
      CSR_MODE_GRAY  = 3'd5,
      CSR_BAND_LOWS  = 3'd6,
      CSR_BAND_HIGHS = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   localparam logic [0:0] OP_SAMPLE = 1'b0;
   localparam logic [0:0] OP_LOAD   = 1'b1;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } gen_type;

   typedef struct packed {
      logic [63:0] view_re;
      logic [63:0] view_im;
      logic [15:0] max_iter;
      logic [28:0] image_size;
      logic [31:0] escape_limit;
      logic        mode_grayscale;
      logic [47:0] band_lows;
      logic [47:0] band_highs;
   } cfg_type;

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic               hit;
      logic [23:0]        pix;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } job_type;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
   } log_req_type;

   typedef struct packed {
      logic             done;
      logic [LOG_W-1:0] value;
   } log_rsp_type;

   typedef struct packed {
      logic       found;
      logic [1:0] chan;
   } band_type;

   function automatic gen_type taus_step(input gen_type g);
      gen_type     n;
      logic [31:0] t;
      t   = ((g.a << 13) ^ g.a) >> 19;
      n.a = ((g.a & TAUS_MASK_A) << 12) ^ t;
      t   = ((g.b << 2) ^ g.b) >> 25;
      n.b = ((g.b & TAUS_MASK_B) << 4) ^ t;
      t   = ((g.c << 3) ^ g.c) >> 11;
      n.c = ((g.c & TAUS_MASK_C) << 17) ^ t;
      return n;
   endfunction

   // First band, from channel 0 upward, whose open interval holds iter.
   function automatic band_type band_pick(input logic [15:0] iter,
                                          input logic [47:0] lows,
                                          input logic [47:0] highs);
      band_type r;
      r.found = 1'b0;
      r.chan  = 2'd0;
      for (int k = 2; k >= 0; k--) begin
         if (iter > lows[16*k +: 16] && iter < highs[16*k +: 16]) begin
            r.found = 1'b1;
            r.chan  = 2'(k);
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/jrsp_fifo.sv @@
// ---------------------------------------------------------------------------
// jrsp_fifo
// Short job queue between the sample front end and the escape-time engine.
// ---------------------------------------------------------------------------
module jrsp_fifo import jrsp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/jrsp_front.sv @@
// ---------------------------------------------------------------------------
// jrsp_front
// Accepts items, runs the taus88 generator, maps the sample to a pixel and a
// window point, and queues the classified job for the back end.
// ---------------------------------------------------------------------------
module jrsp_front import jrsp_pkg::*; #(
   parameter int MAX_SIDE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_seed_a,
   input  logic [31:0] req_seed_b,
   input  logic [31:0] req_seed_c,
   output logic        job_push,
   output job_type     job_data,
   input  logic        job_full
);

   localparam int SW = $clog2(MAX_SIDE) + 1;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   gen_type         gen_ff, gen_in;
   logic            load_ff, load_in;
   logic [31:0]     u1_ff, u2_ff;
   logic [SW+31:0]  prod_x_ff, prod_h_ff;
   logic [32:0]     off_re_ff, off_im_ff;
   logic            neg_re_ff, neg_im_ff;

   gen_type            gen_s1, gen_s2;
   logic [SW-1:0]      w, h;
   logic signed [31:0] lo_re, hi_re, lo_im, hi_im;
   logic signed [32:0] d_re, d_im;
   logic [32:0]        mag_re, mag_im;
   logic [64:0]        prod_re, prod_im;
   logic [SW-1:0]      x, y;
   logic [SW:0]        h_ceil;
   logic [2*SW-1:0]    yw;
   logic [2*SW:0]      pix_full;
   logic signed [33:0] px_w, py_w;
   logic               hit;
   logic               accept;

   assign req_ready = (state_ff == F_IDLE);
   assign accept    = req_valid && req_ready;

   assign gen_s1 = taus_step(gen_ff);
   assign gen_s2 = taus_step(gen_s1);

   // Image sides saturate at MAX_SIDE.
   assign w = (cfg.image_size[15:0] > 16'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                     : SW'(cfg.image_size[15:0]);
   assign h = (cfg.image_size[28:16] > 13'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                      : SW'(cfg.image_size[28:16]);

   assign lo_re  = cfg.view_re[31:0];
   assign hi_re  = cfg.view_re[63:32];
   assign lo_im  = cfg.view_im[31:0];
   assign hi_im  = cfg.view_im[63:32];
   assign d_re   = 33'(hi_re) - 33'(lo_re);
   assign d_im   = 33'(hi_im) - 33'(lo_im);
   assign mag_re = d_re[32] ? 33'(-d_re) : 33'(d_re);
   assign mag_im = d_im[32] ? 33'(-d_im) : 33'(d_im);
   assign prod_re = mag_re * u1_ff;
   assign prod_im = mag_im * u2_ff;

   // y = h - ceil(h * u2 / 2^32)
   assign x        = prod_x_ff[SW+31:32];
   assign h_ceil   = {1'b0, prod_h_ff[SW+31:32]} + (SW+1)'(|prod_h_ff[31:0]);
   assign y        = SW'({1'b0, h} - h_ceil);
   assign yw       = y * w;
   assign pix_full = {{(SW+1){1'b0}}, x} + {1'b0, yw};
   assign hit      = !load_ff && (x != '0) && (y != '0) && (x < w) && (y < h);

   assign px_w = neg_re_ff ? 34'(lo_re) - 34'(off_re_ff) : 34'(lo_re) + 34'(off_re_ff);
   assign py_w = neg_im_ff ? 34'(lo_im) - 34'(off_im_ff) : 34'(lo_im) + 34'(off_im_ff);

   assign job_push     = (state_ff == F_PUSH) && !job_full;
   assign job_data.hit = hit;
   assign job_data.pix = hit ? 24'(pix_full) : 24'd0;
   assign job_data.px  = px_w[31:0];
   assign job_data.py  = py_w[31:0];

   always_comb begin
      state_in = state_ff;
      gen_in   = gen_ff;
      load_in  = load_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  gen_in   = '{a: req_seed_a, b: req_seed_b, c: req_seed_c};
                  load_in  = 1'b1;
                  state_in = F_PUSH;
               end else begin
                  gen_in   = gen_s2;
                  load_in  = 1'b0;
                  state_in = F_MUL;
               end
            end
         end
         F_MUL: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!job_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         gen_ff   <= '{a: SEED_A_RESET, b: SEED_B_RESET, c: SEED_C_RESET};
         load_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         gen_ff   <= gen_in;
         load_ff  <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         u1_ff <= gen_s1.a ^ gen_s1.b ^ gen_s1.c;
         u2_ff <= gen_s2.a ^ gen_s2.b ^ gen_s2.c;
      end
      if (state_ff == F_MUL) begin
         prod_x_ff <= w * u1_ff;
         prod_h_ff <= h * u2_ff;
         off_re_ff <= prod_re[64:32];
         off_im_ff <= prod_im[64:32];
         neg_re_ff <= d_re[32];
         neg_im_ff <= d_im[32];
      end
   end

endmodule

@@ rtl/jrsp_log2.sv @@
// ---------------------------------------------------------------------------
// jrsp_log2
// Sequential log2 with 16 fraction bits: normalize, then one squaring per
// fraction bit.
// ---------------------------------------------------------------------------
module jrsp_log2 import jrsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  log_req_type req,
   output log_rsp_type rsp
);

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_NORM = 3'b010,
      L_SQR  = 3'b100
   } log_state_type;

   log_state_type state_ff, state_in;
   logic [63:0]   x_ff, x_in;
   logic [5:0]    n_ff, n_in;
   logic [31:0]   y_ff, y_in;
   logic [15:0]   frac_ff, frac_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [63:0]   sq;
   logic [32:0]   t;

   assign sq = y_ff * y_ff;
   assign t  = sq[63:31];

   assign rsp.done  = done_ff;
   assign rsp.value = {n_ff, frac_ff};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      n_in     = n_ff;
      y_in     = y_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (req.start) begin
               x_in     = req.x;
               n_in     = 6'd63;
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            // advance toward the leading one, a byte at a time where possible
            if (x_ff[63] || n_ff == '0) begin
               y_in     = x_ff[63:32];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = L_SQR;
            end else if (x_ff[63:56] == '0 && n_ff >= 6'd8) begin
               x_in = x_ff << 8;
               n_in = n_ff - 6'd8;
            end else begin
               x_in = x_ff << 1;
               n_in = n_ff - 6'd1;
            end
         end
         L_SQR: begin
            y_in    = t[32] ? t[32:1] : t[31:0];
            frac_in = {frac_ff[14:0], t[32]};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      n_ff    <= n_in;
      y_ff    <= y_in;
      frac_ff <= frac_in;
   end

endmodule

@@ rtl/jrsp_core.sv @@
// ---------------------------------------------------------------------------
// jrsp_core
// Escape-time engine: iterates z = z^2 + c one step per cycle, computes the
// smooth colour and holds the result in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jrsp_core import jrsp_pkg::*; #(
   parameter int FRAC_BITS = 28,
   parameter int ITER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  job_type     job_data,
   input  logic        job_empty,
   output logic        job_pop,
   output log_req_type log_req,
   input  log_rsp_type log_rsp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [1:0]  rsp_channel,
   output logic [23:0] rsp_pixel_index,
   output logic [16:0] rsp_amount
);

   localparam int          ESC_SH  = 2 * FRAC_BITS - 24;
   localparam logic [63:0] ONE_M   = 64'd1 << (2 * FRAC_BITS);
   localparam logic [LOG_W-1:0] LOG_OFFS = LOG_W'((2 * FRAC_BITS) << 16);
   localparam logic signed [63:0] CX = -(64'sd3 <<< (FRAC_BITS - 2));
   localparam longint CY_L = (64'd27015 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
   localparam logic signed [63:0] CY = 64'(CY_L);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ITER = 5'b00010,
      S_LOGM = 5'b00100,
      S_LOGL = 5'b01000,
      S_OUT  = 5'b10000
   } core_state_type;

   core_state_type       state_ff, state_in;
   logic signed [31:0]   zx_ff, zx_in, zy_ff, zy_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic [1:0]           act_ff, act_in;
   logic [1:0]           chan_ff, chan_in;
   logic [23:0]          pix_ff, pix_in;
   logic [16:0]          amt_ff, amt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           out_act_ff;
   logic [1:0]           out_chan_ff;
   logic [23:0]          out_pix_ff;
   logic [16:0]          out_amt_ff;
   logic                 out_load;

   logic signed [63:0]   xx, yy, xy, diff, nx, ny;
   logic [63:0]          m;
   logic                 escaped;
   logic [ITER_BITS-1:0] limit;
   band_type             band;
   logic [LOG_W-1:0]     l_val;
   logic signed [35:0]   c16;

   assign limit   = cfg.max_iter[ITER_BITS-1:0];
   assign xx      = zx_ff * zx_ff;
   assign yy      = zy_ff * zy_ff;
   assign xy      = zx_ff * zy_ff;
   assign m       = 64'(xx) + 64'(yy);
   assign diff    = xx - yy;
   assign nx      = (diff >>> FRAC_BITS) + CX;
   assign ny      = (xy >>> (FRAC_BITS - 1)) + CY;
   assign escaped = (m >> ESC_SH) >= {32'd0, cfg.escape_limit};
   assign band    = band_pick(16'(iter_ff), cfg.band_lows, cfg.band_highs);
   assign l_val   = log_rsp.value - LOG_OFFS;
   assign c16     = 36'(COLOUR_OFFS) + 36'({iter_ff, 16'd0}) - 36'(log_rsp.value);

   assign job_pop  = (state_ff == S_IDLE) && !job_empty;
   assign out_load = (state_ff == S_OUT) && (!out_valid_ff || rsp_ready);

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v[63:31] == '0 || v[63:31] == '1) begin
         return v[31:0];
      end else if (v[63]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

   always_comb begin
      state_in     = state_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      iter_in      = iter_ff;
      act_in       = act_ff;
      chan_in      = chan_ff;
      pix_in       = pix_ff;
      amt_in       = amt_ff;
      out_valid_in = out_valid_ff;
      log_req      = '{start: 1'b0, x: m};
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               zx_in   = job_data.px;
               zy_in   = job_data.py;
               iter_in = '0;
               pix_in  = job_data.pix;
               chan_in = 2'd0;
               amt_in  = '0;
               if (job_data.hit) begin
                  act_in   = ACT_ADD;
                  state_in = S_ITER;
               end else begin
                  act_in   = ACT_NONE;
                  state_in = S_OUT;
               end
            end
         end
         S_ITER: begin
            if (iter_ff >= limit || escaped) begin
               if (iter_ff == limit) begin
                  act_in   = ACT_CLEAR;
                  state_in = S_OUT;
               end else begin
                  if (cfg.mode_grayscale) begin
                     act_in = ACT_ADD;
                  end else begin
                     act_in  = band.found ? ACT_ADD : ACT_NONE;
                     chan_in = band.chan;
                  end
                  if (m < ONE_M) begin
                     state_in = S_OUT;
                  end else begin
                     log_req.start = 1'b1;
                     state_in      = S_LOGM;
                  end
               end
            end else begin
               zx_in   = sat32(nx);
               zy_in   = sat32(ny);
               iter_in = iter_ff + 1'b1;
            end
         end
         S_LOGM: begin
            log_req.x = 64'(l_val);
            if (log_rsp.done) begin
               if (l_val == '0) begin
                  amt_in   = AMOUNT_MAX;
                  state_in = S_OUT;
               end else begin
                  log_req.start = 1'b1;
                  state_in      = S_LOGL;
               end
            end
         end
         S_LOGL: begin
            if (log_rsp.done) begin
               if (c16 < 0) begin
                  amt_in = '0;
               end else if (c16[35:16] > 20'(AMOUNT_MAX)) begin
                  amt_in = AMOUNT_MAX;
               end else begin
                  amt_in = c16[32:16];
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         iter_ff      <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      zx_ff   <= zx_in;
      zy_ff   <= zy_in;
      act_ff  <= act_in;
      chan_ff <= chan_in;
      pix_ff  <= pix_in;
      amt_ff  <= amt_in;
      if (out_load) begin
         // drop the side fields of results that touch no pixel
         out_act_ff  <= act_ff;
         out_chan_ff <= (act_ff == ACT_NONE) ? 2'd0 : chan_ff;
         out_pix_ff  <= (act_ff == ACT_NONE) ? 24'd0 : pix_ff;
         out_amt_ff  <= (act_ff == ACT_ADD) ? amt_ff : 17'd0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_action      = out_act_ff;
   assign rsp_channel     = out_chan_ff;
   assign rsp_pixel_index = out_pix_ff;
   assign rsp_amount      = out_amt_ff;

   `JRSP_ASSERT(a_none_is_empty, clock, reset,
      rsp_valid && rsp_action == ACT_NONE |->
         rsp_channel == 2'd0 && rsp_pixel_index == 24'd0 && rsp_amount == 17'd0)
   `JRSP_ASSERT(a_clear_no_amount, clock, reset,
      rsp_valid && rsp_action == ACT_CLEAR |-> rsp_amount == 17'd0 && rsp_channel == 2'd0)
   `JRSP_ASSERT(a_iter_bounded, clock, reset, state_ff == S_ITER |-> iter_ff <= limit)
   `JRSP_NEVER(a_pop_while_busy, clock, reset, job_pop && state_ff != S_IDLE)

endmodule

@@ rtl/julia_random_sample_plotter.sv @@
// ---------------------------------------------------------------------------
// julia_random_sample_plotter
// Random-sample Julia plotter: draws taus88 samples, runs the escape-time
// iteration and emits one pixel action per item.
// ---------------------------------------------------------------------------
// Each item yields exactly one result. A seed load passes through the front
// end's idle and push states; a sample goes through its generator, multiply
// and pixel-map steps, then in the back end through a start step, the
// iteration of z = z^2 + c (up to max_iter steps), a stop step and, for
// escaped points, up to two passes of the log2 unit (each a normalize phase,
// one squaring per fraction bit and a hand-back of the value). The
// one-squaring-per-cycle iteration loop sets the rate while rsp_ready does
// not hold the output register; the 2-entry job queue lets the front end
// take the next item while the back end is still iterating or its result
// waits in the output register.
module julia_random_sample_plotter import jrsp_pkg::*; #(
   parameter int MAX_SIDE    = 4096,
   parameter int FRAC_BITS   = 28,
   parameter int ITER_BITS   = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_seed_a,
   input  logic [31:0] req_seed_b,
   input  logic [31:0] req_seed_c,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [1:0]  rsp_channel,
   output logic [23:0] rsp_pixel_index,
   output logic [16:0] rsp_amount
);

   cfg_type     cfg_ff;
   job_type     push_data, pop_data;
   logic        push, pop, full, empty;
   log_req_type log_req;
   log_rsp_type log_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_re        <= '0;
         cfg_ff.view_im        <= '0;
         cfg_ff.max_iter       <= 16'd256;
         cfg_ff.image_size     <= 29'd50332672;
         cfg_ff.escape_limit   <= 32'd67108864;
         cfg_ff.mode_grayscale <= 1'b1;
         cfg_ff.band_lows      <= '0;
         cfg_ff.band_highs     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIEW_RE:    cfg_ff.view_re        <= csr_wdata;
            CSR_VIEW_IM:    cfg_ff.view_im        <= csr_wdata;
            CSR_MAX_ITER:   cfg_ff.max_iter       <= csr_wdata[15:0];
            CSR_IMAGE_SIZE: cfg_ff.image_size     <= csr_wdata[28:0];
            CSR_ESCAPE:     cfg_ff.escape_limit   <= csr_wdata[31:0];
            CSR_MODE_GRAY:  cfg_ff.mode_grayscale <= csr_wdata[0];
            CSR_BAND_LOWS:  cfg_ff.band_lows      <= csr_wdata[47:0];
            CSR_BAND_HIGHS: cfg_ff.band_highs     <= csr_wdata[47:0];
            default: begin
            end
         endcase
      end
   end

   jrsp_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_seed_a (req_seed_a),
      .req_seed_b (req_seed_b),
      .req_seed_c (req_seed_c),
      .job_push   (push),
      .job_data   (push_data),
      .job_full   (full)
   );

   jrsp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   jrsp_log2 u_log2 (
      .clock (clock),
      .reset (reset),
      .req   (log_req),
      .rsp   (log_rsp)
   );

   jrsp_core #(.FRAC_BITS(FRAC_BITS), .ITER_BITS(ITER_BITS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .job_data        (pop_data),
      .job_empty       (empty),
      .job_pop         (pop),
      .log_req         (log_req),
      .log_rsp         (log_rsp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_channel     (rsp_channel),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_amount      (rsp_amount)
   );

endmodule
